>>> rtl/khopca_pkg.sv
// Shared types and constants for the k-hop clustering weight engine.
// Used by khopca_nbr_mem and khopca_cluster_weight_engine_top; no dependencies.
package khopca_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int ADDR_W     = 32;
  localparam int WEIGHT_W   = 8;
  localparam int POWER_W    = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_O_W  = 5;

  // Item kinds carried in the mode field.
  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TICKS   = 2'd3;

  // Configuration reset values.
  localparam logic [WEIGHT_W-1:0] RST_MAX_WEIGHT     = 8'd4;
  localparam logic [WEIGHT_W-1:0] RST_MIN_WEIGHT     = 8'd1;
  localparam logic [WEIGHT_W-1:0] RST_INITIAL_WEIGHT = 8'd1;
  localparam logic [TIME_W-1:0]   RST_EXPIRE_TICKS   = 32'd11;

  // One neighbor table entry as stored in the memory.
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [WEIGHT_W-1:0] weight;
    logic [POWER_W-1:0]  power;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

  // Write request into the neighbor memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Decrement that stops at zero.
  function automatic logic [WEIGHT_W-1:0] dec_sat(input logic [WEIGHT_W-1:0] v);
    dec_sat = (v == '0) ? v : v - WEIGHT_W'(1);
  endfunction

endpackage

>>> rtl/khopca_nbr_mem.sv
// Neighbor table storage: one synchronous memory, one write and one read port.
// Depends on khopca_pkg for the entry layout and table depth.
module khopca_nbr_mem (
  input  logic                           clk_i,
  input  khopca_pkg::mem_wr_t            wr_i,
  input  logic [khopca_pkg::IDX_W-1:0]   rd_addr_i,
  output khopca_pkg::entry_t             rd_data_o
);
  import khopca_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port: the word appears in the cycle after its address.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/khopca_cluster_weight_engine_top.sv
// Top level of the k-hop clustering weight engine: sequencer, valid bits and rules.
// Depends on khopca_pkg and khopca_nbr_mem.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+--------------------------------------------
//   in       | in_valid_i / in_ready_o | mode, now_time, sender_*, own_power
//   out      | out_valid_o/out_ready_i | weight, is_head, weight_changed,
//            |                         | neighbor_count, report_dropped
//   cfg      | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// An item is accepted in the idle state, then walks the table with one memory read
// per table entry, drains the last read and finishes.
// The walk is set by the single read port of the neighbor memory.
// Reset clears all valid bits at once and loads the own weight; no clearing pass.
// A result waits in the output register; the next item is accepted meanwhile, and
// it holds in its finishing cycle until the previous result has been transferred.
module khopca_cluster_weight_engine_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic [khopca_pkg::TIME_W-1:0]        now_time_i,
  input  logic [khopca_pkg::ADDR_W-1:0]        sender_addr_i,
  input  logic [khopca_pkg::WEIGHT_W-1:0]      sender_weight_i,
  input  logic [khopca_pkg::POWER_W-1:0]       sender_power_i,
  input  logic [khopca_pkg::POWER_W-1:0]       own_power_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [khopca_pkg::WEIGHT_W-1:0]      weight_o,
  output logic                                 is_head_o,
  output logic                                 weight_changed_o,
  output logic [khopca_pkg::COUNT_O_W-1:0]     neighbor_count_o,
  output logic                                 report_dropped_o,
  // Configuration port.
  input  logic                                 cfg_we_i,
  input  logic [khopca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [khopca_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import khopca_pkg::*;

  // Configuration registers.
  logic [WEIGHT_W-1:0] max_weight_q, min_weight_q;
  logic [TIME_W-1:0]   expire_q;

  // Sequencer and item registers.
  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q;
  logic                rd_pend_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic                mode_q;
  logic [TIME_W-1:0]   now_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [WEIGHT_W-1:0] sw_q;
  logic [POWER_W-1:0]  sp_q;
  logic [POWER_W-1:0]  op_q;

  // Walk results.
  logic                found_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_q;
  logic [WEIGHT_W-1:0] max_nbr_q;
  logic                stronger_q;

  // Table state outside the memory.
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]       count_q;
  logic [WEIGHT_W-1:0]    own_weight_q;

  // Output register.
  logic                out_valid_q;
  logic [WEIGHT_W-1:0] out_weight_q;
  logic                out_head_q;
  logic                out_changed_q;
  logic [CNT_W-1:0]    out_count_q;
  logic                out_dropped_q;

  // Memory interface.
  mem_wr_t mem_wr;
  entry_t  rd_data;

  khopca_nbr_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Handshake terms.
  logic in_xfer, fin_go, last_idx;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign fin_go   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign last_idx = (idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  // Per-entry evaluation of the word that just came out of the memory.
  logic [TIME_W:0]   limit;
  logic [TIME_W-1:0] age;
  logic              ent_valid, ent_hit, ent_stale;
  assign limit     = {1'b0, expire_q} + (TIME_W + 1)'(1);
  assign age       = now_q - rd_data.stamp;
  assign ent_valid = valid_q[rd_idx_q];
  assign ent_hit   = rd_pend_q && (mode_q == MODE_REPORT) && ent_valid &&
                     (rd_data.addr == addr_q);
  assign ent_stale = rd_pend_q && (mode_q == MODE_TICK) && ent_valid &&
                     ({1'b0, age} > limit);

  // Report completion terms.
  logic do_insert, do_drop;
  assign do_insert = fin_go && (mode_q == MODE_REPORT) && !found_q && free_found_q;
  assign do_drop   = (mode_q == MODE_REPORT) && !found_q && !free_found_q;

  // Memory writes: overwrite a matching entry during the walk, insert at the end.
  always_comb begin
    mem_wr.en   = ent_hit || do_insert;
    mem_wr.addr = ent_hit ? rd_idx_q : free_q;
    mem_wr.data = '{addr: addr_q, weight: sw_q, power: sp_q, stamp: now_q};
  end

  // Clustering rules on a tick, applied in order after expiry.
  logic                warm;
  logic [WEIGHT_W-1:0] w1, w2, w3, w4, w_rule, w_new;
  always_comb begin
    warm = ({1'b0, now_q} > limit);
    w1 = (max_nbr_q > own_weight_q) ? max_nbr_q - WEIGHT_W'(1) : own_weight_q;
    w2 = (max_nbr_q == min_weight_q && w1 == min_weight_q) ? max_weight_q : w1;
    w3 = (max_nbr_q <= w2 && w2 != max_weight_q && max_nbr_q != '0) ?
         dec_sat(w2) : w2;
    w4 = (max_nbr_q == max_weight_q && w3 == max_weight_q && stronger_q) ?
         dec_sat(w3) : w3;
    w_rule = (count_q == '0) ? min_weight_q : w4;
    w_new  = ((mode_q == MODE_TICK) && warm) ? w_rule : own_weight_q;
  end

  // Count after the finishing step.
  logic [CNT_W-1:0] count_fin;
  assign count_fin = do_insert ? count_q + CNT_W'(1) : count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_WALK;
      ST_WALK:   if (last_idx) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: if (fin_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; the initial weight goes straight into the own weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_weight_q     <= RST_MAX_WEIGHT;
      min_weight_q     <= RST_MIN_WEIGHT;
      expire_q         <= RST_EXPIRE_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_WEIGHT:     max_weight_q     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_MIN_WEIGHT:     min_weight_q     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_INITIAL_WEIGHT: ;
        CFG_EXPIRE_TICKS:   expire_q         <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Own weight, valid bits and entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_weight_q <= RST_INITIAL_WEIGHT;
      valid_q      <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_INITIAL_WEIGHT) begin
        own_weight_q <= cfg_data_i[WEIGHT_W-1:0];
      end else if (fin_go) begin
        own_weight_q <= w_new;
      end
      if (ent_stale) begin
        valid_q[rd_idx_q] <= 1'b0;
        count_q           <= count_q - CNT_W'(1);
      end else if (do_insert) begin
        valid_q[free_q] <= 1'b1;
        count_q         <= count_fin;
      end
    end
  end

  // Walk control: read index and the pending read marker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_WALK);
      if (state_q == ST_WALK) begin
        idx_q <= last_idx ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  // Item payload and walk accumulators.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (in_xfer) begin
      mode_q       <= mode_i;
      now_q        <= now_time_i;
      addr_q       <= sender_addr_i;
      sw_q         <= sender_weight_i;
      sp_q         <= sender_power_i;
      op_q         <= own_power_i;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_q       <= '0;
      max_nbr_q    <= '0;
      stronger_q   <= 1'b0;
    end else if (rd_pend_q) begin
      if (ent_hit) begin
        found_q <= 1'b1;
      end
      if (!ent_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_q       <= rd_idx_q;
      end
      // Surviving neighbors feed the rule inputs.
      if ((mode_q == MODE_TICK) && ent_valid && !ent_stale) begin
        if (rd_data.weight > max_nbr_q) begin
          max_nbr_q <= rd_data.weight;
        end
        if (rd_data.power > op_q) begin
          stronger_q <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_weight_q  <= w_new;
      out_head_q    <= (w_new == max_weight_q);
      out_changed_q <= (w_new != own_weight_q);
      out_count_q   <= count_fin;
      out_dropped_q <= do_drop;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign weight_o         = out_weight_q;
  assign is_head_o        = out_head_q;
  assign weight_changed_o = out_changed_q;
  assign neighbor_count_o = COUNT_O_W'(out_count_q);
  assign report_dropped_o = out_dropped_q;

endmodule
